// ===== hdl/source_token_scanner_assert.svh =====
// Assertion macros for the scanner's RTL.
`ifndef SOURCE_TOKEN_SCANNER_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define STS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition at one edge that forces another at the next edge.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Types, token codes and keyword tables of the source token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

	localparam int DEF_MAX_KEYWORD_CHARS = 6;
	localparam int DEF_LINE_BITS         = 24;
	localparam int LINE_OUT_W            = 24;
	localparam int QUEUE_DEPTH           = 4;
	localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
	localparam int FILL_W                = $clog2(QUEUE_DEPTH + 1);
	localparam int NUM_KEYWORDS          = 34;
	localparam int KW_CHARS              = 6;
	localparam logic [4:0] FRAC_MAX      = 5'd19;

	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_TEXT  = 1'b1;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
	localparam logic [1:0] ERR_BAD_REAL = 2'd2;
	localparam logic [1:0] ERR_NO_QUOTE = 2'd3;

	localparam logic [5:0] TK_EOF = 6'd0, TK_NAME = 6'd1, TK_INT = 6'd2,
		TK_REAL = 6'd3, TK_STRING = 6'd4, TK_DIV = 6'd5, TK_PLUS = 6'd6,
		TK_COND = 6'd7, TK_MINUS = 6'd8, TK_POWER = 6'd9, TK_MULT = 6'd10,
		TK_DOT = 6'd11, TK_ASS = 6'd12, TK_COLON = 6'd13, TK_BAR = 6'd14,
		TK_COMMA = 6'd15, TK_LPAREN = 6'd16, TK_RPAREN = 6'd17,
		TK_LBRACKET = 6'd18, TK_RBRACKET = 6'd19, TK_LBRACE = 6'd20,
		TK_RBRACE = 6'd21, TK_NOSHARE = 6'd22, TK_LOGAND = 6'd23,
		TK_LOGOR = 6'd24, TK_GR = 6'd25, TK_LS = 6'd26, TK_PERCENT = 6'd27,
		TK_SEQ = 6'd28, TK_VALDEF = 6'd29, TK_JJ = 6'd30, TK_AND = 6'd31,
		TK_AUG = 6'd32, TK_DEF = 6'd33, TK_DO = 6'd34, TK_DUMMY = 6'd35,
		TK_EQ = 6'd36, TK_FALSE = 6'd37, TK_LAMBDA = 6'd38, TK_GE = 6'd39,
		TK_GOTO = 6'd40, TK_IF = 6'd41, TK_IFNOT = 6'd42, TK_IFSO = 6'd43,
		TK_IN = 6'd44, TK_LE = 6'd45, TK_LET = 6'd46, TK_NE = 6'd47,
		TK_NIL = 6'd48, TK_NOT = 6'd49, TK_REC = 6'd50, TK_RES = 6'd51,
		TK_TEST = 6'd52, TK_TRUE = 6'd53, TK_VALOF = 6'd54, TK_WHERE = 6'd55,
		TK_WHILE = 6'd56, TK_WITHIN = 6'd57;

	// Keyword text is right-justified: the last character sits in bits 7:0.
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
		48'("J"), 48'("and"), 48'("aug"), 48'("def"), 48'("do"), 48'("dummy"),
		48'("eq"), 48'("false"), 48'("fn"), 48'("ge"), 48'("goto"), 48'("gr"),
		48'("if"), 48'("ifnot"), 48'("ifso"), 48'("in"), 48'("jj"), 48'("le"),
		48'("let"), 48'("ll"), 48'("ls"), 48'("ne"), 48'("nil"), 48'("not"),
		48'("or"), 48'("rec"), 48'("res"), 48'("test"), 48'("true"),
		48'("val"), 48'("valof"), 48'("where"), 48'("while"), 48'("within")};

	localparam int KW_LEN [NUM_KEYWORDS] = '{
		1, 3, 3, 3, 2, 5, 2, 5, 2, 2, 4, 2, 2, 5, 4, 2, 2, 2,
		3, 2, 2, 2, 3, 3, 2, 3, 3, 4, 4, 3, 5, 5, 5, 6};

	localparam logic [5:0] KW_CODE [NUM_KEYWORDS] = '{
		TK_JJ, TK_AND, TK_AUG, TK_DEF, TK_DO, TK_DUMMY, TK_EQ, TK_FALSE,
		TK_LAMBDA, TK_GE, TK_GOTO, TK_GR, TK_IF, TK_IFNOT, TK_IFSO, TK_IN,
		TK_JJ, TK_LE, TK_LET, TK_LAMBDA, TK_LS, TK_NE, TK_NIL, TK_NOT,
		TK_LOGOR, TK_REC, TK_RES, TK_TEST, TK_TRUE, TK_VALOF, TK_VALOF,
		TK_WHERE, TK_WHILE, TK_WITHIN};

	typedef struct packed {
		logic [7:0] src_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic                  item_kind;
		logic [5:0]            token_code;
		logic [LINE_OUT_W-1:0] line_number;
		logic [63:0]           int_value;
		logic [63:0]           frac_value;
		logic [4:0]            frac_digits;
		logic [7:0]            text_char;
		logic [1:0]            error_code;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              empty;
	} q_stat_t;

	function automatic res_t mk_res(logic kind, logic [5:0] code,
		logic [LINE_OUT_W-1:0] line, logic [63:0] iv, logic [63:0] fv,
		logic [4:0] fd, logic [7:0] tc, logic [1:0] err);
		res_t r;
		r.item_kind   = kind;
		r.token_code  = code;
		r.line_number = line;
		r.int_value   = iv;
		r.frac_value  = fv;
		r.frac_digits = fd;
		r.text_char   = tc;
		r.error_code  = err;
		r.last        = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sts_stream_if.sv =====
// ----------------------------------------------------------------------------
// sts_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sts_front.sv =====
// ----------------------------------------------------------------------------
// sts_front
// Scanner front end: accepts source bytes, tracks the open token and
// produces up to two results per item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front import sts_pkg::*; #(
	parameter int MAX_KEYWORD_CHARS = DEF_MAX_KEYWORD_CHARS,
	parameter int LINE_BITS         = DEF_LINE_BITS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sts_stream_if.sink    items_in,
	input  wire q_stat_t  stat,
	output push_t         push
);

	localparam int LEN_W = $clog2(MAX_KEYWORD_CHARS + 2);
	localparam int IDX_W = $clog2(MAX_KEYWORD_CHARS);
	localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

	localparam logic [3:0] M_START = 4'd0, M_COMMENT = 4'd1, M_SLASH = 4'd2,
		M_MINUS = 4'd3, M_STAR = 4'd4, M_COLON = 4'd5, M_STR = 4'd6,
		M_ESC = 4'd7, M_INT = 4'd8, M_POINT = 4'd9, M_FRAC = 4'd10,
		M_IDENT = 4'd11;

	logic [3:0]           mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [63:0]          int_q, int_d, frac_q, frac_d;
	logic [4:0]           fcnt_q, fcnt_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [7:0]           chars_q [MAX_KEYWORD_CHARS];
	logic                 chr_we;
	logic [IDX_W-1:0]     chr_idx;

	logic [LINE_BITS+LINE_OUT_W-1:0] line_wide;
	logic [LINE_OUT_W-1:0]           line_out;
	logic                            accept;
	logic [7:0]                      c;
	logic [63:0]                     dig;
	logic                            is_dig, is_alp, is_spc;
	logic [5:0]                      single, kw_code;
	logic                            va, vb, fresh;
	res_t                            a_r, b_r;

	assign line_wide = {{LINE_OUT_W{1'b0}}, line_q};
	assign line_out  = line_wide[LINE_OUT_W-1:0];
	assign items_in.ready = (stat.fill <= FILL_W'(QUEUE_DEPTH - 2));
	assign accept = items_in.valid && items_in.ready;
	assign c = items_in.data.src_byte;
	assign dig = {60'd0, c[3:0] - 4'd0};
	assign is_dig = (c >= "0") && (c <= "9");
	assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
	assign is_spc = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));

	function automatic logic [5:0] single_code(logic [7:0] ch);
		logic [5:0] r;
		unique case (ch)
			"+": r = TK_PLUS;     ".": r = TK_DOT;      "!": r = TK_BAR;
			",": r = TK_COMMA;    "(": r = TK_LPAREN;   ")": r = TK_RPAREN;
			"[": r = TK_LBRACKET; "]": r = TK_RBRACKET; "{": r = TK_LBRACE;
			"}": r = TK_RBRACE;   "$": r = TK_NOSHARE;  "&": r = TK_LOGAND;
			"|": r = TK_LOGOR;    ">": r = TK_GR;       "<": r = TK_LS;
			"%": r = TK_PERCENT;  ";": r = TK_SEQ;      "=": r = TK_VALDEF;
			default: r = TK_EOF;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] unescape(logic [7:0] ch);
		logic [7:0] r;
		unique case (ch)
			"n": r = 8'h0a; "t": r = 8'h09; "s": r = 8'h20;
			"b": r = 8'h08; "*": r = "*";   "'": r = "'";
			default: r = 8'h0a;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] times10(logic [63:0] x, logic [63:0] d);
		return {x[60:0], 3'b000} + {x[62:0], 1'b0} + d;
	endfunction

	assign single = single_code(c);

	// Keyword match over the stored name characters.
	always_comb begin
		logic hit;
		int   pos;
		kw_code = TK_NAME;
		for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
			hit = (int'(len_q) == KW_LEN[k]);
			for (int j = 0; j < KW_CHARS; j++) begin
				pos = (j < KW_LEN[k]) ? (KW_LEN[k] - 1 - j) : 0;
				if (j < KW_LEN[k] && chars_q[j] != KW_TEXT[k][8*pos +: 8])
					hit = 1'b0;
			end
			if (hit)
				kw_code = KW_CODE[k];
		end
	end

	always_comb begin
		mode_d  = mode_q;
		line_d  = line_q;
		int_d   = int_q;
		frac_d  = frac_q;
		fcnt_d  = fcnt_q;
		len_d   = len_q;
		chr_we  = 1'b0;
		chr_idx = len_q[IDX_W-1:0];
		va      = 1'b0;
		vb      = 1'b0;
		fresh   = 1'b0;
		a_r     = mk_res(KIND_TOKEN, TK_EOF, line_out, '0, '0, '0, '0, ERR_NONE);
		b_r     = a_r;
		if (items_in.data.end_of_input) begin
			va = 1'b1;
			unique case (mode_q)
				M_SLASH: a_r.token_code = TK_DIV;
				M_MINUS: a_r.token_code = TK_MINUS;
				M_STAR:  a_r.token_code = TK_MULT;
				M_COLON: a_r.token_code = TK_COLON;
				M_STR, M_ESC: begin
					a_r.token_code = TK_STRING;
					a_r.error_code = ERR_NO_QUOTE;
				end
				M_INT: begin
					a_r.token_code = TK_INT;
					a_r.int_value  = int_q;
				end
				M_POINT: begin
					a_r.token_code = TK_REAL;
					a_r.int_value  = int_q;
					a_r.error_code = ERR_BAD_REAL;
				end
				M_FRAC: begin
					a_r = mk_res(KIND_TOKEN, TK_REAL, line_out, int_q, frac_q, fcnt_q,
						'0, ERR_NONE);
				end
				M_IDENT: a_r.token_code = kw_code;
				default: va = 1'b0;
			endcase
			vb     = 1'b1;
			mode_d = M_START;
			line_d = LINE_BITS'(1);
			int_d  = '0;
			frac_d = '0;
			fcnt_d = '0;
			len_d  = '0;
		end else begin
			unique case (mode_q)
				M_COMMENT: begin
					if (c == 8'h0a) begin
						if (line_q != LINE_TOP) line_d = line_q + 1'b1;
						mode_d = M_START;
					end
				end
				M_SLASH: begin
					if (c == "/") mode_d = M_COMMENT;
					else begin
						va = 1'b1; a_r.token_code = TK_DIV; fresh = 1'b1;
					end
				end
				M_MINUS: begin
					va = 1'b1;
					if (c == ">") begin
						a_r.token_code = TK_COND; mode_d = M_START;
					end else begin
						a_r.token_code = TK_MINUS; fresh = 1'b1;
					end
				end
				M_STAR: begin
					va = 1'b1;
					if (c == "*") begin
						a_r.token_code = TK_POWER; mode_d = M_START;
					end else begin
						a_r.token_code = TK_MULT; fresh = 1'b1;
					end
				end
				M_COLON: begin
					va = 1'b1;
					if (c == "=") begin
						a_r.token_code = TK_ASS; mode_d = M_START;
					end else begin
						a_r.token_code = TK_COLON; fresh = 1'b1;
					end
				end
				M_STR: begin
					if (c == "'") begin
						va = 1'b1; a_r.token_code = TK_STRING; mode_d = M_START;
					end else if (c == "*") begin
						mode_d = M_ESC;
					end else begin
						va = 1'b1;
						a_r = mk_res(KIND_TEXT, TK_STRING, line_out, '0, '0, '0, c,
							ERR_NONE);
					end
				end
				M_ESC: begin
					va = 1'b1;
					a_r = mk_res(KIND_TEXT, TK_STRING, line_out, '0, '0, '0,
						unescape(c), ERR_NONE);
					mode_d = M_STR;
				end
				M_INT: begin
					if (is_dig) int_d = times10(int_q, dig);
					else if (c == ".") mode_d = M_POINT;
					else begin
						va = 1'b1;
						a_r.token_code = TK_INT;
						a_r.int_value  = int_q;
						fresh = 1'b1;
					end
				end
				M_POINT, M_FRAC: begin
					if (is_dig) begin
						if (fcnt_q < FRAC_MAX) begin
							frac_d = times10(frac_q, dig);
							fcnt_d = fcnt_q + 1'b1;
						end
						mode_d = M_FRAC;
					end else begin
						va = 1'b1;
						a_r = mk_res(KIND_TOKEN, TK_REAL, line_out, int_q, frac_q, fcnt_q,
							'0, (mode_q == M_POINT) ? ERR_BAD_REAL : ERR_NONE);
						fresh = 1'b1;
					end
				end
				M_IDENT: begin
					va = 1'b1;
					if (is_alp || is_dig) begin
						if (int'(len_q) < MAX_KEYWORD_CHARS) chr_we = 1'b1;
						if (int'(len_q) <= MAX_KEYWORD_CHARS) len_d = len_q + 1'b1;
						a_r = mk_res(KIND_TEXT, TK_NAME, line_out, '0, '0, '0, c,
							ERR_NONE);
					end else begin
						a_r.token_code = kw_code;
						fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase

			// The byte that closed a token, or any byte in the start state.
			if (fresh) begin
				mode_d = M_START;
				priority if (is_spc) begin
					if (c == 8'h0a && line_q != LINE_TOP) line_d = line_q + 1'b1;
				end else if (c == "/") mode_d = M_SLASH;
				else if (c == "-") mode_d = M_MINUS;
				else if (c == "*") mode_d = M_STAR;
				else if (c == ":") mode_d = M_COLON;
				else if (c == "'") mode_d = M_STR;
				else if (single != TK_EOF) begin
					vb = 1'b1; b_r.token_code = single;
				end else if (is_dig) begin
					int_d  = dig;
					frac_d = '0;
					fcnt_d = '0;
					mode_d = M_INT;
				end else if (is_alp) begin
					chr_we  = 1'b1;
					chr_idx = '0;
					len_d   = LEN_W'(1);
					vb      = 1'b1;
					b_r = mk_res(KIND_TEXT, TK_NAME, line_out, '0, '0, '0, c, ERR_NONE);
					mode_d = M_IDENT;
				end else begin
					vb = 1'b1;
					b_r.text_char  = c;
					b_r.error_code = ERR_ILLEGAL;
				end
			end
		end
	end

	always_comb begin
		push.count = accept ? ({1'b0, va} + {1'b0, vb}) : 2'd0;
		push.r0    = va ? a_r : b_r;
		push.r1    = b_r;
		push.r0.last = !(va && vb);
		push.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			line_q <= LINE_BITS'(1);
			int_q  <= '0;
			frac_q <= '0;
			fcnt_q <= '0;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			line_q <= line_d;
			int_q  <= int_d;
			frac_q <= frac_d;
			fcnt_q <= fcnt_d;
			len_q  <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chr_we)
			chars_q[chr_idx] <= c;
	end

endmodule

`default_nettype wire

// ===== hdl/sts_queue.sv =====
// ----------------------------------------------------------------------------
// sts_queue
// Short result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_queue import sts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire push_t   push,
	input  wire logic    pop,
	output res_t         head,
	output q_stat_t      stat
);

	res_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [FILL_W-1:0] fill_q;

	assign head       = slot_q[rd_q];
	assign stat.fill  = fill_q;
	assign stat.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			slot_q[wr_q] <= push.r0;
		if (push.count == 2'd2)
			slot_q[wr_q + 1'b1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + QPTR_W'(push.count);
			rd_q   <= rd_q + QPTR_W'(pop);
			fill_q <= fill_q + FILL_W'(push.count) - FILL_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sts_back.sv =====
// ----------------------------------------------------------------------------
// sts_back
// Output stage: moves queued results into the registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_back import sts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire res_t    head,
	input  wire q_stat_t stat,
	output logic         pop,
	sts_stream_if.source tokens_out
);

	logic valid_q;
	res_t data_q;

	assign pop = !stat.empty && (!valid_q || tokens_out.ready);
	assign tokens_out.valid = valid_q;
	assign tokens_out.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (pop) valid_q <= 1'b1;
		else if (tokens_out.ready) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) data_q <= head;
	end

endmodule

`default_nettype wire

// ===== hdl/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner
// Streaming lexical scanner: source bytes in, tokens and name/string
// characters out.
// ----------------------------------------------------------------------------
// The scanner takes one source byte per cycle and decides its results in the
// same cycle; a byte gives at most two results, which enter a four-entry
// queue in front of a registered output stage that hands out one result per
// cycle while the receiver is ready. Input is accepted while at least two
// queue entries are free, so the input rate is one byte per cycle as long as
// results are taken at the rate they are made; a result passes from the
// queue into the output register before it appears at the output.
`default_nettype none

module source_token_scanner import sts_pkg::*; #(
	parameter int MAX_KEYWORD_CHARS = DEF_MAX_KEYWORD_CHARS,
	parameter int LINE_BITS         = DEF_LINE_BITS
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sts_stream_if.sink   items_in,
	sts_stream_if.source tokens_out
);

	push_t   push;
	q_stat_t stat;
	res_t    head;
	logic    pop;

	sts_front #(
		.MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS),
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .items_in(items_in), .stat(stat), .push(push)
	);

	sts_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(pop), .head(head), .stat(stat)
	);

	sts_back u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .stat(stat), .pop(pop),
		.tokens_out(tokens_out)
	);

`include "source_token_scanner_assert.svh"

	`STS_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, stat.fill <= FILL_W'(QUEUE_DEPTH), "queue overflow")
	`STS_ASSERT_ALWAYS(a_ready_room, clk, arst_n, !items_in.ready || stat.fill <= FILL_W'(QUEUE_DEPTH - 2), "input ready without room")
	`STS_ASSERT_NEXT(a_idle_quiet, clk, arst_n, stat.empty && !tokens_out.valid, !tokens_out.valid, "output from an empty queue")

endmodule

`default_nettype wire
